[hw/rtl/psg_pkg.sv]
// Shared types, constants and the volume table for the three-voice sound generator.
// No dependencies; every other file in hw/rtl imports this package.
package psg_pkg;

    localparam int OVERSAMPLE_BITS_DEF = 3;
    localparam int VOLUME_WIDTH_DEF    = 16;
    localparam int VOICES              = 3;

    localparam int CFG_WIDTH  = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int PERIOD_W   = 24;
    localparam int SETUP_W    = 21;
    localparam int MIX_W      = 6;
    localparam int LFSR_W     = 17;
    localparam int ROM_W      = 16;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_TONE_A      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_B      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_C      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_STEP  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_ENABLES = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_PERIOD  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_SHAPE   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VOICE_SETUP = 4'd7;

    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 17'h12000;
    localparam logic [LFSR_W-1:0] LFSR_SEED  = 17'h00001;
    localparam logic [4:0]        ENV_IDX_TOP  = 5'd15;
    localparam logic [4:0]        ENV_IDX_DONE = 5'h1f;
    localparam logic [3:0]        ENV_LVL_MAX  = 4'hf;

    typedef struct packed {
        logic                restart;
        logic [3:0]          shape;
        logic [PERIOD_W-1:0] period;
    } env_cfg_t;

    typedef struct packed {
        logic       mute_right;
        logic       mute_left;
        logic       use_env;
        logic [3:0] level;
    } voice_cfg_t;

    function automatic logic [ROM_W-1:0] volume_lookup(input logic [3:0] idx);
        logic [ROM_W-1:0] v;
        begin
            case (idx)
                4'd0:    v = 16'd0;
                4'd1:    v = 16'd508;
                4'd2:    v = 16'd719;
                4'd3:    v = 16'd1018;
                4'd4:    v = 16'd1440;
                4'd5:    v = 16'd2038;
                4'd6:    v = 16'd2883;
                4'd7:    v = 16'd4080;
                4'd8:    v = 16'd5772;
                4'd9:    v = 16'd8168;
                4'd10:   v = 16'd11556;
                4'd11:   v = 16'd16351;
                4'd12:   v = 16'd23136;
                4'd13:   v = 16'd32735;
                4'd14:   v = 16'd46317;
                default: v = 16'd65535;
            endcase
            return v;
        end
    endfunction

    function automatic logic [LFSR_W-1:0] lfsr_shift(input logic [LFSR_W-1:0] s);
        begin
            return (s >> 1) ^ (s[0] ? LFSR_TAPS : '0);
        end
    endfunction

endpackage

[hw/rtl/psg_env.sv]
// Envelope generator: countdown, step index, mode bits and current level.
// Depends on psg_pkg.
module psg_env (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  psg_pkg::env_cfg_t  cfg,
    output logic [3:0]         level
);
    import psg_pkg::*;

    logic [PERIOD_W-1:0] cd_reg, cd_next, cd_dec;
    logic [4:0]          idx_reg, idx_next, idx_dec;
    logic [3:0]          mode_reg, mode_next;
    logic [3:0]          lvl_reg, lvl_next;

    assign cd_dec  = cd_reg - 1'b1;
    assign idx_dec = idx_reg - 1'b1;

    always_comb
    begin
        cd_next   = cd_reg;
        idx_next  = idx_reg;
        mode_next = mode_reg;
        lvl_next  = lvl_reg;
        if (cfg.restart)
        begin
            mode_next = cfg.shape;
            idx_next  = ENV_IDX_TOP;
            lvl_next  = ENV_LVL_MAX ^ {4{cfg.shape[0]}};
            cd_next   = cfg.period;
        end
        else if (step_en && cd_reg != '0)
        begin
            if (cd_dec != '0)
            begin
                cd_next = cd_dec;
            end
            else if (idx_reg == '0)
            begin
                if (mode_reg[1])
                begin
                    // one-shot end: freeze at the final level
                    lvl_next = mode_reg[2] ? ENV_LVL_MAX : 4'h0;
                    idx_next = ENV_IDX_DONE;
                    cd_next  = '0;
                end
                else
                begin
                    mode_next = mode_reg[3] ? mode_reg : (mode_reg ^ 4'b0001);
                    idx_next  = ENV_IDX_TOP;
                    cd_next   = cfg.period;
                    lvl_next  = ENV_LVL_MAX ^ {4{mode_next[0]}};
                end
            end
            else
            begin
                idx_next = idx_dec;
                cd_next  = cfg.period;
                lvl_next = idx_dec[3:0] ^ {4{mode_reg[0]}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg   <= '0;
            idx_reg  <= ENV_IDX_TOP;
            mode_reg <= '0;
            lvl_reg  <= ENV_LVL_MAX;
        end
        else
        begin
            cd_reg   <= cd_next;
            idx_reg  <= idx_next;
            mode_reg <= mode_next;
            lvl_reg  <= lvl_next;
        end
    end

    // the level used by this sample is the one after this sample's advance
    assign level = lvl_next;

    assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg == ENV_IDX_DONE) |-> (cd_reg == '0))
        else $error("envelope past its end but countdown still running");

endmodule

[hw/rtl/psg_noise.sv]
// Noise source: fractional divider and 17-bit LFSR, all sub-steps of one sample.
// Depends on psg_pkg.
module psg_noise #(
    parameter int OVERSAMPLE_BITS = psg_pkg::OVERSAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic                          run,
    input  logic [31:0]                   noise_step,
    output logic [(1<<OVERSAMPLE_BITS)-1:0] noise_bits
);
    import psg_pkg::*;

    localparam int SUBSTEPS = 1 << OVERSAMPLE_BITS;

    logic [31:0]       div_reg, div_next;
    logic [LFSR_W-1:0] shift_reg, shift_next;

    always_comb
    begin
        logic [LFSR_W-1:0] sh;
        logic [31:0]       d;
        sh = shift_reg;
        for (int k = 0; k < SUBSTEPS; k++)
        begin
            // divider value before sub-step k, independent of the other sub-steps
            d = div_reg - 32'(noise_step * 32'(k));
            if (d > noise_step)
            begin
                sh = lfsr_shift(sh);
            end
            noise_bits[k] = sh[0];
        end
        shift_next = sh;
        div_next   = div_reg - (noise_step << OVERSAMPLE_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg   <= '0;
            shift_reg <= LFSR_SEED;
        end
        else if (step_en && run)
        begin
            div_reg   <= div_next;
            shift_reg <= shift_next;
        end
    end

endmodule

[hw/rtl/psg_voice.sv]
// One square-wave voice: phase accumulator and the signed sample sum of one tick.
// Depends on psg_pkg.
module psg_voice #(
    parameter int OVERSAMPLE_BITS = psg_pkg::OVERSAMPLE_BITS_DEF,
    parameter int VOLUME_WIDTH    = psg_pkg::VOLUME_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  logic [31:0]                     tone_step,
    input  logic [1:0]                      sel,
    input  logic [VOLUME_WIDTH-1:0]         vol,
    input  logic [(1<<OVERSAMPLE_BITS)-1:0] noise_bits,
    output logic [31:0]                     samp
);
    import psg_pkg::*;

    localparam int SUBSTEPS = 1 << OVERSAMPLE_BITS;
    localparam int CNT_W    = OVERSAMPLE_BITS + 1;
    localparam int FAC_W    = OVERSAMPLE_BITS + 3;

    logic [31:0]             phase_reg;
    logic [CNT_W-1:0]        up_cnt;
    logic signed [FAC_W-1:0] fac;
    logic                    active;

    assign active = (vol != '0) && (sel != 2'b00);

    always_comb
    begin
        logic [31:0] ph;
        logic        tone_up;
        logic        up;
        up_cnt = '0;
        for (int k = 0; k < SUBSTEPS; k++)
        begin
            ph      = phase_reg + 32'(tone_step * 32'(k + 1));
            tone_up = !ph[31];
            case (sel)
                2'b01:   up = tone_up;
                2'b10:   up = noise_bits[k];
                default: up = tone_up | noise_bits[k];
            endcase
            up_cnt = up_cnt + CNT_W'(up);
        end
    end

    // sum of +vol / -vol over the sub-steps = vol * (2*ups - substeps)
    assign fac  = $signed({1'b0, up_cnt, 1'b0}) - $signed(FAC_W'(SUBSTEPS));
    assign samp = active ? (32'(vol) * 32'(fac)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (step_en && active && sel[0])
        begin
            phase_reg <= phase_reg + (tone_step << OVERSAMPLE_BITS);
        end
    end

endmodule

[hw/rtl/psg_three_voice_sample_generator.sv]
// Three-voice sound generator, top level: config registers, request handshake and mix.
// Depends on psg_pkg, psg_env, psg_noise and psg_voice.
//
// Each request carries the running left/right mix and returns it with the three
// voices added. A request is taken every cycle unless the input side stalls; it passes
// through the input register and then the result register, and all envelope, noise and
// phase work for all 2^OVERSAMPLE_BITS sub-steps runs as one pass between them.
// The input side stalls only while a result is held by a stalled output and a
// request already waits in the input register. Write configuration only while no
// request is in flight; a write to env_shape restarts the envelope.
module psg_three_voice_sample_generator #(
    parameter int OVERSAMPLE_BITS = psg_pkg::OVERSAMPLE_BITS_DEF,
    parameter int VOLUME_WIDTH    = psg_pkg::VOLUME_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [psg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psg_pkg::CFG_WIDTH-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [31:0]                  acc_left,
    input  logic signed [31:0]                  acc_right,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [31:0]                  mix_left,
    output logic signed [31:0]                  mix_right
);
    import psg_pkg::*;

    localparam int SUBSTEPS = 1 << OVERSAMPLE_BITS;
    localparam int VOL_UP   = (VOLUME_WIDTH >= ROM_W) ? (VOLUME_WIDTH - ROM_W) : 0;
    localparam int VOL_DOWN = (VOLUME_WIDTH <  ROM_W) ? (ROM_W - VOLUME_WIDTH) : 0;

    logic [31:0]         tone_step_reg [VOICES];
    logic [31:0]         noise_step_reg;
    logic [MIX_W-1:0]    mix_en_reg;
    logic [PERIOD_W-1:0] env_period_reg;
    logic [SETUP_W-1:0]  voice_setup_reg;

    logic               s1_valid_reg, s1_valid_next;
    logic signed [31:0] s1_left_reg, s1_right_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_left_reg, out_right_reg;
    logic signed [31:0] left_next, right_next;

    logic out_free, s1_adv, in_take;

    env_cfg_t             env_cfg;
    logic [3:0]           env_level;
    logic [SUBSTEPS-1:0]  noise_bits;
    logic [31:0]          voice_samp [VOICES];
    voice_cfg_t           vcfg [VOICES];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                tone_step_reg[v] <= '0;
            end
            noise_step_reg  <= '0;
            mix_en_reg      <= '0;
            env_period_reg  <= '0;
            voice_setup_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TONE_A:      tone_step_reg[0] <= cfg_data;
                REG_TONE_B:      tone_step_reg[1] <= cfg_data;
                REG_TONE_C:      tone_step_reg[2] <= cfg_data;
                REG_NOISE_STEP:  noise_step_reg   <= cfg_data;
                REG_MIX_ENABLES: mix_en_reg       <= cfg_data[MIX_W-1:0];
                REG_ENV_PERIOD:  env_period_reg   <= cfg_data[PERIOD_W-1:0];
                REG_VOICE_SETUP: voice_setup_reg  <= cfg_data[SETUP_W-1:0];
                default: ;
            endcase
        end
    end

    assign env_cfg.restart = cfg_we && (cfg_index == REG_ENV_SHAPE);
    assign env_cfg.shape   = cfg_data[3:0];
    assign env_cfg.period  = env_period_reg;

    // Handshake: the input register advances whenever the result register frees up
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_left_reg  <= acc_left;
            s1_right_reg <= acc_right;
        end
        if (s1_adv)
        begin
            out_left_reg  <= left_next;
            out_right_reg <= right_next;
        end
    end

    psg_env u_env (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (s1_adv),
        .cfg     (env_cfg),
        .level   (env_level)
    );

    psg_noise #(
        .OVERSAMPLE_BITS (OVERSAMPLE_BITS)
    ) u_noise (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (s1_adv),
        .run        (mix_en_reg[5:3] != 3'b000),
        .noise_step (noise_step_reg),
        .noise_bits (noise_bits)
    );

    for (genvar v = 0; v < VOICES; v++)
    begin : g_voice
        logic [3:0]                    vol_idx;
        logic [VOLUME_WIDTH+ROM_W-1:0] vol_wide;
        logic [VOLUME_WIDTH-1:0]       vol;

        assign vcfg[v]  = voice_cfg_t'(voice_setup_reg[7*v +: 7]);
        assign vol_idx  = vcfg[v].use_env ? env_level : vcfg[v].level;
        assign vol_wide = ({{VOLUME_WIDTH{1'b0}}, volume_lookup(vol_idx)} << VOL_UP) >> VOL_DOWN;
        assign vol      = vol_wide[VOLUME_WIDTH-1:0];

        psg_voice #(
            .OVERSAMPLE_BITS (OVERSAMPLE_BITS),
            .VOLUME_WIDTH    (VOLUME_WIDTH)
        ) u_voice (
            .clk        (clk),
            .rst_n      (rst_n),
            .step_en    (s1_adv),
            .tone_step  (tone_step_reg[v]),
            .sel        ({mix_en_reg[3+v], mix_en_reg[v]}),
            .vol        (vol),
            .noise_bits (noise_bits),
            .samp       (voice_samp[v])
        );
    end

    // Drop muted voices from each side; sums wrap at 32 bits
    always_comb
    begin
        logic [31:0] l;
        logic [31:0] r;
        l = s1_left_reg;
        r = s1_right_reg;
        for (int v = 0; v < VOICES; v++)
        begin
            if (!vcfg[v].mute_left)
            begin
                l = l + voice_samp[v];
            end
            if (!vcfg[v].mute_right)
            begin
                r = r + voice_samp[v];
            end
        end
        left_next  = l;
        right_next = r;
    end

    assign out_valid = out_valid_reg;
    assign mix_left  = out_left_reg;
    assign mix_right = out_right_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("request left input register but no result is shown");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && !s1_valid_reg) |-> !in_stall)
        else $error("input stalled with an empty input register");

endmodule
